FILE: rtl/pmtw_pkg.sv
package pmtw_pkg;

  typedef struct packed {
    logic               action;
    logic [11:0]        virtual_address;
    logic signed [31:0] write_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [7:0]         physical_address;
  } rsp_t;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

endpackage

FILE: rtl/pmtw_ram.sv
module pmtw_ram #(
  parameter int AW    = 8,
  parameter int DW    = 32,
  parameter int DEPTH = 256
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/paged_memory_with_table_walk_eviction.sv
// Channel   Ports              Handshake
// request   start, busy, req   taken on a rising edge with start high and busy low
// result    done, rsp          done high for one cycle; the receiver cannot stall
//
// A word whose table path is present reads and evaluates one table entry per level,
// then raises done from the access state for a write or from the read state after it for a read.
// A missing entry costs a depth-first walk of the tables, ending early at the first empty
// table frame, on the single frame memory read port, then the unlink, swap and restore
// sweeps and the clear, each going word by word.
// After reset the frame memory is cleared, one word a cycle, FRAMES * 2**OFFSET_BITS
// words in all, while busy is high. Every word gives exactly one result.
module paged_memory_with_table_walk_eviction #(
  parameter int OFFSET_BITS = 4,
  parameter int LEVELS      = 2,
  parameter int FRAMES      = 16,
  parameter int WORD_BITS   = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  pmtw_pkg::req_t req,
  output logic           done,
  output pmtw_pkg::rsp_t rsp
);

  localparam int OB      = OFFSET_BITS;
  localparam int FW      = $clog2(FRAMES);
  localparam int AW      = FW + OB;
  localparam int FDEPTH  = FRAMES * (1 << OB);
  localparam int PB      = OB * LEVELS;
  localparam int VAW     = OB * (LEVELS + 1);
  localparam int NPAGES  = 1 << PB;
  localparam int LVW     = $clog2(LEVELS + 1);
  localparam int WB      = WORD_BITS;
  localparam bit FR_POW2 = (FRAMES == (1 << FW));

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_TRD, S_TEV, S_NODE, S_SRD, S_SEV, S_NEXT, S_SEND, S_LEAF,
    S_LCMP, S_POP, S_DONE, S_URD, S_UEV, S_CPRD, S_CPWR, S_CLR, S_RSRD, S_RSWR,
    S_LINK, S_ACC, S_ARD
  } state_t;

  state_t state;

  logic           fm_we;
  logic [AW-1:0]  fm_waddr;
  logic [AW-1:0]  fm_raddr;
  logic [WB-1:0]  fm_wdata;
  logic [WB-1:0]  fm_rdata;
  logic           sw_we;
  logic [VAW-1:0] sw_waddr;
  logic [VAW-1:0] sw_raddr;
  logic [WB-1:0]  sw_wdata;
  logic [WB-1:0]  sw_rdata;

  logic           action;
  logic [VAW-1:0] va;
  logic [WB-1:0]  wval;
  logic [LVW-1:0] lvl_i;
  logic [FW-1:0]  cur;
  logic [FW-1:0]  nxt;
  logic [AW-1:0]  icnt;
  logic [OB-1:0]  cnt;

  logic [FW-1:0]  frm [0:LEVELS];
  logic [OB-1:0]  row [0:LEVELS];
  logic [PB-1:0]  pg  [0:LEVELS];
  logic [LVW-1:0] lvl;
  logic           nz;
  logic [FW-1:0]  avoid;
  logic [FW-1:0]  top;
  logic           ef;
  logic [FW-1:0]  ef_frame;
  logic [FW-1:0]  ef_parent;
  logic           vf;
  logic [FW-1:0]  v_frame;
  logic [FW-1:0]  v_parent;
  logic [PB-1:0]  v_page;
  logic [PB:0]    best;
  logic [PB:0]    leaf_dist;
  logic [FW-1:0]  upar;
  logic [FW-1:0]  uchild;
  logic [NPAGES-1:0] swapped;

  logic [OB-1:0]  tidx;
  logic [OB-1:0]  off;
  logic [PB-1:0]  want;
  logic           lk_ok;
  logic [FW-1:0]  child;
  logic [PB-1:0]  dabs;
  logic [PB:0]    dalt;
  logic [FW:0]    top_inc;

  assign tidx    = va[(LEVELS - int'(lvl_i)) * OB +: OB];
  assign off     = va[OB-1:0];
  assign want    = va[VAW-1:OB];
  assign busy    = (state != S_IDLE);
  assign top_inc = {1'b0, top} + (FW + 1)'(1);

  always_comb begin
    lk_ok = ((fm_rdata >> FW) == '0) && (FR_POW2 || (fm_rdata[FW-1:0] < FW'(FRAMES)));
    child = lk_ok ? fm_rdata[FW-1:0] : '0;
    dabs  = (want > pg[lvl]) ? (want - pg[lvl]) : (pg[lvl] - want);
    dalt  = ((PB + 1)'(1) << PB) - {1'b0, dabs};
  end

  always_comb begin
    fm_we    = 1'b0;
    fm_waddr = '0;
    fm_wdata = '0;
    fm_raddr = '0;
    sw_we    = 1'b0;
    sw_waddr = '0;
    sw_wdata = '0;
    sw_raddr = '0;
    case (state)
      S_INIT: begin
        fm_we    = 1'b1;
        fm_waddr = icnt;
      end
      S_TRD: fm_raddr = {cur, tidx};
      S_SRD: fm_raddr = {frm[lvl], row[lvl]};
      S_URD: fm_raddr = {upar, cnt};
      S_UEV: begin
        fm_we    = (fm_rdata == WB'(uchild));
        fm_waddr = {upar, cnt};
      end
      S_CPRD: fm_raddr = {v_frame, cnt};
      S_CPWR: begin
        sw_we    = 1'b1;
        sw_waddr = {v_page, cnt};
        sw_wdata = fm_rdata;
      end
      S_CLR: begin
        fm_we    = 1'b1;
        fm_waddr = {nxt, cnt};
      end
      S_RSRD: sw_raddr = {want, cnt};
      S_RSWR: begin
        fm_we    = 1'b1;
        fm_waddr = {nxt, cnt};
        fm_wdata = sw_rdata;
      end
      S_LINK: begin
        fm_we    = 1'b1;
        fm_waddr = {cur, tidx};
        fm_wdata = WB'(nxt);
      end
      S_ACC: begin
        fm_we    = (action == pmtw_pkg::ACT_WRITE);
        fm_waddr = {cur, off};
        fm_wdata = wval;
        fm_raddr = {cur, off};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      icnt    <= '0;
      done    <= 1'b0;
      swapped <= '0;
      lvl     <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_INIT: begin
          icnt <= icnt + AW'(1);
          if (icnt == AW'(FDEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            action <= req.action;
            va     <= VAW'(req.virtual_address);
            wval   <= WB'(req.write_value);
            lvl_i  <= '0;
            cur    <= '0;
            state  <= S_TRD;
          end
        end
        S_TRD: state <= S_TEV;
        S_TEV: begin
          if (child != '0) begin
            cur <= child;
            if (lvl_i == LVW'(LEVELS - 1)) begin
              state <= S_ACC;
            end else begin
              lvl_i <= lvl_i + LVW'(1);
              state <= S_TRD;
            end
          end else begin
            avoid  <= cur;
            top    <= '0;
            ef     <= 1'b0;
            vf     <= 1'b0;
            best   <= '0;
            lvl    <= '0;
            frm[0] <= '0;
            pg[0]  <= '0;
            state  <= S_NODE;
          end
        end
        S_NODE: begin
          if (lvl == LVW'(LEVELS)) begin
            state <= S_LEAF;
          end else begin
            row[lvl] <= '0;
            nz       <= 1'b0;
            state    <= S_SRD;
          end
        end
        S_SRD: state <= S_SEV;
        S_SEV: begin
          if (fm_rdata != '0) begin
            nz <= 1'b1;
          end
          if (child != '0) begin
            if (child > top) begin
              top <= child;
            end
            frm[LVW'(lvl + LVW'(1))] <= child;
            pg[LVW'(lvl + LVW'(1))]  <= PB'({pg[lvl], row[lvl]});
            lvl   <= lvl + LVW'(1);
            state <= S_NODE;
          end else begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (row[lvl] == '1) begin
            state <= S_SEND;
          end else begin
            row[lvl] <= row[lvl] + OB'(1);
            state    <= S_SRD;
          end
        end
        S_SEND: begin
          if (frm[lvl] != '0 && frm[lvl] != avoid && !nz) begin
            ef        <= 1'b1;
            ef_frame  <= frm[lvl];
            ef_parent <= frm[LVW'(lvl - LVW'(1))];
            state     <= S_DONE;
          end else begin
            state <= S_POP;
          end
        end
        S_LEAF: begin
          leaf_dist <= ({1'b0, dabs} < dalt) ? {1'b0, dabs} : dalt;
          state     <= S_LCMP;
        end
        S_LCMP: begin
          if (!vf || leaf_dist > best) begin
            vf       <= 1'b1;
            best     <= leaf_dist;
            v_frame  <= frm[lvl];
            v_parent <= frm[LVW'(lvl - LVW'(1))];
            v_page   <= pg[lvl];
          end
          state <= S_POP;
        end
        S_POP: begin
          if (lvl == '0) begin
            state <= S_DONE;
          end else begin
            lvl   <= lvl - LVW'(1);
            nz    <= 1'b1;
            state <= S_NEXT;
          end
        end
        S_DONE: begin
          cnt <= '0;
          if (ef) begin
            upar   <= ef_parent;
            uchild <= ef_frame;
            nxt    <= ef_frame;
            state  <= S_URD;
          end else if (top_inc < (FW + 1)'(FRAMES)) begin
            nxt   <= top_inc[FW-1:0];
            state <= S_CLR;
          end else if (vf) begin
            upar   <= v_parent;
            uchild <= v_frame;
            nxt    <= v_frame;
            state  <= S_CPRD;
          end else begin
            rsp   <= '0;
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_CPRD: state <= S_CPWR;
        S_CPWR: begin
          cnt <= cnt + OB'(1);
          if (cnt == '1) begin
            swapped[v_page] <= 1'b1;
            state           <= S_URD;
          end else begin
            state <= S_CPRD;
          end
        end
        S_URD: state <= S_UEV;
        S_UEV: begin
          cnt <= cnt + OB'(1);
          state <= (cnt == '1) ? S_CLR : S_URD;
        end
        S_CLR: begin
          cnt <= cnt + OB'(1);
          if (cnt == '1) begin
            if (lvl_i == LVW'(LEVELS - 1) && swapped[want]) begin
              state <= S_RSRD;
            end else begin
              state <= S_LINK;
            end
          end
        end
        S_RSRD: state <= S_RSWR;
        S_RSWR: begin
          cnt <= cnt + OB'(1);
          if (cnt == '1) begin
            swapped[want] <= 1'b0;
            state         <= S_LINK;
          end else begin
            state <= S_RSRD;
          end
        end
        S_LINK: begin
          cur <= nxt;
          if (lvl_i == LVW'(LEVELS - 1)) begin
            state <= S_ACC;
          end else begin
            lvl_i <= lvl_i + LVW'(1);
            state <= S_TRD;
          end
        end
        S_ACC: begin
          rsp.physical_address <= 8'({cur, off});
          if (action == pmtw_pkg::ACT_WRITE) begin
            rsp.read_value <= '0;
            done           <= 1'b1;
            state          <= S_IDLE;
          end else begin
            state <= S_ARD;
          end
        end
        S_ARD: begin
          rsp.read_value <= 32'(fm_rdata);
          done           <= 1'b1;
          state          <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  pmtw_ram #(.AW(AW), .DW(WB), .DEPTH(FDEPTH)) u_frame_mem (
    .clk   (clk),
    .we    (fm_we),
    .waddr (fm_waddr),
    .wdata (fm_wdata),
    .raddr (fm_raddr),
    .rdata (fm_rdata)
  );

  pmtw_ram #(.AW(VAW), .DW(WB), .DEPTH(1 << VAW)) u_swap_mem (
    .clk   (clk),
    .we    (sw_we),
    .waddr (sw_waddr),
    .wdata (sw_wdata),
    .raddr (sw_raddr),
    .rdata (sw_rdata)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE) else $error("result shown outside idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted word did not raise busy");

  a_frame_range: assert property (@(posedge clk) disable iff (rst)
    fm_we |-> fm_waddr <= AW'(FDEPTH - 1)) else $error("frame write out of range");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    lvl <= LVW'(LEVELS)) else $error("walk deeper than the table levels");

endmodule
